// ===== design/rvm_pkg.sv =====
// ----------------------------------------------------------------------------
// rvm_pkg: shared constants and types for the RMS volume meter
// Fixed field widths, scaling constants and the status bundle that the
// serial arithmetic units report to the sequencer.
// ----------------------------------------------------------------------------
package rvm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 7;
  localparam int USED_W   = 9;

  // Multiplier operand width of the shift-add unit: one bit retired per cycle
  localparam int MUL_W    = 16;

  // 32767 * 32767, the squared full-scale amplitude
  localparam logic [29:0]        FULL_SCALE_SQ = 30'd1073676289;
  // 100 * 100, the square of the level range
  localparam logic [MUL_W-1:0]   LEVEL_SCALE   = 16'd10000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 7'd100;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== design/rvm_serial_mul.sv =====
// ----------------------------------------------------------------------------
// rvm_serial_mul: bit-serial shift-add multiplier
// Retires one multiplier bit per cycle; a pulse on done marks the product.
// ----------------------------------------------------------------------------
module rvm_serial_mul
  import rvm_pkg::*;
#(
  parameter int P_W = 53
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [P_W-1:0]   mcand_in,
  input  logic [MUL_W-1:0] mplier_in,
  output unit_status_t     status,
  output logic [P_W-1:0]   product
);

  localparam int STEP_W = $clog2(MUL_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MUL_W - 1);

  logic             running;
  logic             done;
  logic [STEP_W-1:0] step;
  logic [P_W-1:0]   acc;
  logic [P_W-1:0]   mcand;
  logic [MUL_W-1:0] mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == STEP_LAST) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand when the low multiplier bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= mcand_in;
      mplier <= mplier_in;
    end else if (running) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[P_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[MUL_W-1:1]};
    end
  end

  assign status.busy = running;
  assign status.done = done;
  assign product     = acc;

endmodule

// ===== design/rvm_level_search.sv =====
// ----------------------------------------------------------------------------
// rvm_level_search: incremental search for the largest level
// Walks L upward, keeping L*L*unit by adding odd multiples of unit, and stops
// at the last L whose total stays within the bound, or at the top of the range.
// ----------------------------------------------------------------------------
module rvm_level_search
  import rvm_pkg::*;
#(
  parameter int P_W = 53
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [P_W-1:0]     bound,
  input  logic [P_W-1:0]     unit,
  output unit_status_t       status,
  output logic [LEVEL_W-1:0] level
);

  logic               running;
  logic               done;
  logic [LEVEL_W-1:0] lvl;
  logic [P_W-1:0]     total;   // lvl*lvl*unit
  logic [P_W-1:0]     delta;   // (2*lvl+1)*unit
  logic [P_W-1:0]     unit2;
  logic [P_W:0]       total_try;
  logic               fits;

  assign total_try = {1'b0, total} + {1'b0, delta};
  assign fits      = (total_try <= {1'b0, bound}) && (lvl != LEVEL_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && !fits) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lvl   <= '0;
      total <= '0;
      delta <= unit;
      unit2 <= {unit[P_W-2:0], 1'b0};
    end else if (running && fits) begin
      lvl   <= lvl + LEVEL_W'(1);
      total <= total_try[P_W-1:0];
      delta <= delta + unit2;
    end
  end

  assign status.busy = running;
  assign status.done = done;
  assign level       = lvl;

endmodule

// ===== design/rms_volume_meter_core.sv =====
// ----------------------------------------------------------------------------
// rms_volume_meter_core: block RMS level meter for 16-bit audio
// Accumulates squared samples per block and, on the block's last sample,
// reports the RMS level scaled to 0..100 and the number of samples used.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Payload                 | Direction
//  --------+---------------------+-------------------------+----------
//  in      | in_valid / in_stall | sample, block_end       | into core
//  out     | out_valid/out_stall | level, samples_used     | out of core
//
//  A sample is accepted, squared bit-serially in the shared shift-add
//  multiplier and accumulated. A block's last sample adds two more serial
//  products (10000*sum and 32767^2*count) and the level search, one level
//  a cycle. One request is worked on at a time; in_stall is high while it is.
//  Reset clears the sequencer, both accumulators and the output valid.
//  A result held under out_stall does not block the next samples; only the
//  next block's result waits for the output register to free.
//
module rms_volume_meter_core
  import rvm_pkg::*;
#(
  parameter int BLOCK_MAX = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                block_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LEVEL_W-1:0]  level,
  output logic [USED_W-1:0]   samples_used
);

  // Count holds 0..BLOCK_MAX; the sum of squares is at most 2^30 per count
  localparam int CNT_W = $clog2(BLOCK_MAX + 1);
  localparam int SUM_W = 30 + CNT_W;
  // Products: 10000*sum and up to 101^2 * 32767^2 * count
  localparam int P_W   = 44 + CNT_W;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SQUARE  = 7'b0000010,
    ST_CLOSE   = 7'b0000100,
    ST_SCALE_R = 7'b0001000,
    ST_SCALE_U = 7'b0010000,
    ST_SEARCH  = 7'b0100000,
    ST_EMIT    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [SUM_W-1:0]    square_sum;
  logic [CNT_W-1:0]    sample_count;
  logic                last;
  logic [P_W-1:0]      bound;

  logic                in_accept;
  logic                out_accept;
  logic                take;
  logic [SAMPLE_W-1:0] mag;
  logic                out_free;

  logic                mul_start;
  logic [P_W-1:0]      mul_mcand;
  logic [MUL_W-1:0]    mul_mplier;
  unit_status_t        mul_status;
  logic [P_W-1:0]      mul_product;

  logic                search_start;
  unit_status_t        search_status;
  logic [LEVEL_W-1:0]  search_level;

  assign in_stall   = (state != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign out_free   = !out_valid || !out_stall;

  // Drop samples once the block is full; the block end still closes it
  assign take = (sample_count < CNT_W'(BLOCK_MAX));
  // Magnitude of a two's-complement sample; full-scale negative gives 0x8000
  assign mag  = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;

  // Sequencer and operand selection for the shared multiplier
  always_comb begin
    state_next   = state;
    mul_start    = 1'b0;
    mul_mcand    = '0;
    mul_mplier   = '0;
    search_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (take) begin
            mul_start  = !mul_status.busy;
            mul_mcand  = P_W'(mag);
            mul_mplier = mag;
            state_next = ST_SQUARE;
          end else if (block_end) begin
            state_next = ST_CLOSE;
          end
        end
      end
      ST_SQUARE: begin
        if (mul_status.done) begin
          state_next = last ? ST_CLOSE : ST_IDLE;
        end
      end
      ST_CLOSE: begin
        mul_start  = !mul_status.busy;
        mul_mcand  = P_W'(square_sum);
        mul_mplier = LEVEL_SCALE;
        state_next = ST_SCALE_R;
      end
      ST_SCALE_R: begin
        if (mul_status.done) begin
          mul_start  = 1'b1;
          mul_mcand  = P_W'(FULL_SCALE_SQ);
          mul_mplier = MUL_W'(sample_count);
          state_next = ST_SCALE_U;
        end
      end
      ST_SCALE_U: begin
        if (mul_status.done) begin
          search_start = 1'b1;
          state_next   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_status.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold here while the previous result still waits at the output
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accumulators: add the finished square, clear once the result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (state == ST_SQUARE && mul_status.done) begin
      square_sum   <= square_sum + SUM_W'(mul_product);
      sample_count <= sample_count + CNT_W'(1);
    end else if (state == ST_EMIT && out_free) begin
      square_sum   <= '0;
      sample_count <= '0;
    end
  end

  // Request payload that outlives the accept cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      last <= block_end;
    end
    if (state == ST_SCALE_R && mul_status.done) begin
      bound <= mul_product;
    end
  end

  // Output register: load from the search, release on the downstream accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      level        <= search_level;
      samples_used <= USED_W'(sample_count);
    end
  end

  rvm_serial_mul #(
    .P_W (P_W)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (mul_mcand),
    .mplier_in (mul_mplier),
    .status    (mul_status),
    .product   (mul_product)
  );

  rvm_level_search #(
    .P_W (P_W)
  ) u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (search_start),
    .bound  (bound),
    .unit   (mul_product),
    .status (search_status),
    .level  (search_level)
  );

endmodule

// ===== design/rvm_checker.sv =====
// ----------------------------------------------------------------------------
// rvm_checker: port-level checks for the RMS volume meter
// Watches the two channels of the core and flags range, hold, ordering and reset slips.
// ----------------------------------------------------------------------------
module rvm_checker
  import rvm_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                block_end,
  input logic                out_valid,
  input logic                out_stall,
  input logic [LEVEL_W-1:0]  level,
  input logic [USED_W-1:0]   samples_used
);

  // Level never leaves its scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level <= LEVEL_MAX))
    else $error("level above full scale");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(level) && $stable(samples_used)))
    else $error("stalled result changed");

  // A block end is worked on before the next request is taken
  a_block_end_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && block_end) |=> in_stall)
    else $error("request taken while block result pending");

  // A result appears only while the input side is held
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a pending block");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid survived reset");

endmodule

bind rms_volume_meter_core rvm_checker u_rvm_checker (.*);
